// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: geometry constants, command codes and
// the request and result payload types. It depends on nothing else.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CURSOR_W   = 12;
  localparam int POS_W      = 11;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUESTION = 8'h3f;
  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CH_RETURN   = 8'h0d;
  localparam logic [7:0] CH_HIGH     = 8'h80;
  localparam logic [7:0] ATTR_RESET  = 8'h0f;

  localparam logic [CURSOR_W-1:0] CURSOR_END  = CURSOR_W'(CELL_COUNT);
  localparam logic [CURSOR_W-1:0] CURSOR_COLS = CURSOR_W'(COLUMNS);

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [7:0]       char_byte;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_now;
    logic [7:0]          cell_char;
    logic [7:0]          cell_attr;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: command decode, cursor, screen store
// and configuration port. It depends on tcw_pkg.
`default_nettype none

// A request is taken when start is high and busy is low; its result appears
// on result, marked by result_valid, which is high for exactly one cycle, in
// the cycle after the request finishes, and must be taken then. Set cursor and
// a read past the screen end finish in their accept cycle; read cell issues
// the store's registered read in its accept cycle and finishes in S_READ; a
// put of an ordinary byte or newline finishes in S_PUT. Carriage return divides
// the cursor by repeated subtraction of the row width in S_MOD. A put with the
// cursor at or past the screen end first scrolls, copying one cell per cycle
// through the store's single read and write ports. Clear writes one cell per
// cycle. The store is undefined after reset until a clear.
module text_console_writer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tcw_pkg::req_t request,
  output logic               result_valid,
  output tcw_pkg::rsp_t      result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUT    = 6'b000010,
    S_SCROLL = 6'b000100,
    S_MOD    = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_READ   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [tcw_pkg::CURSOR_W-1:0] cursor, cursor_next;
  logic [tcw_pkg::CURSOR_W-1:0] rem, rem_next;
  logic [7:0]                   attr;
  logic [7:0]                   put_char, put_char_next;
  logic [tcw_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic                         sc_pend, sc_pend_next;
  logic [tcw_pkg::ADDR_W-1:0]   sc_wa, sc_wa_next;

  logic [15:0]                  mem [tcw_pkg::CELL_COUNT];
  logic                         mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [15:0]                  mem_wdata, mem_rdata;

  logic                         accept, emit;
  logic [7:0]                   emit_char, emit_attr;
  logic [tcw_pkg::CURSOR_W-1:0] pos_ext;
  logic                         cfg_write;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign pos_ext   = tcw_pkg::CURSOR_W'(request.position);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {24'd0, attr};

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    rem_next      = rem;
    put_char_next = put_char;
    cnt_next      = cnt;
    sc_pend_next  = 1'b0;
    sc_wa_next    = sc_wa;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = cnt[tcw_pkg::ADDR_W-1:0];
    mem_raddr     = request.position[tcw_pkg::ADDR_W-1:0];
    mem_wdata     = {attr, tcw_pkg::CH_SPACE};
    emit          = 1'b0;
    emit_char     = 8'd0;
    emit_attr     = 8'd0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (request.command)
            tcw_pkg::CMD_PUT: begin
              put_char_next = request.char_byte;
              state_next    = S_PUT;
            end
            tcw_pkg::CMD_SET: begin
              cursor_next = (pos_ext > tcw_pkg::CURSOR_END) ? tcw_pkg::CURSOR_END : pos_ext;
              emit        = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              if (pos_ext < tcw_pkg::CURSOR_END) begin
                mem_re     = 1'b1;
                state_next = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cnt_next   = '0;
              state_next = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PUT: begin
        if (cursor >= tcw_pkg::CURSOR_END) begin
          cnt_next   = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
          state_next = S_SCROLL;
        end else if (put_char == tcw_pkg::CH_NEWLINE) begin
          cursor_next = cursor + tcw_pkg::CURSOR_COLS;
          emit        = 1'b1;
          state_next  = S_IDLE;
        end else if (put_char == tcw_pkg::CH_RETURN) begin
          rem_next   = cursor;
          state_next = S_MOD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cursor[tcw_pkg::ADDR_W-1:0];
          if (put_char < tcw_pkg::CH_SPACE || put_char >= tcw_pkg::CH_HIGH) begin
            mem_wdata = {attr, tcw_pkg::CH_QUESTION};
          end else begin
            mem_wdata = {attr, put_char};
          end
          cursor_next = cursor + tcw_pkg::CURSOR_W'(1);
          emit        = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCROLL: begin
        mem_raddr = cnt[tcw_pkg::ADDR_W-1:0];
        mem_re    = (cnt < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT));
        mem_we    = sc_pend;
        mem_waddr = sc_wa;
        mem_wdata = mem_rdata;
        if (mem_re) begin
          sc_pend_next = 1'b1;
          sc_wa_next   = tcw_pkg::ADDR_W'(cnt - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
          cnt_next     = cnt + tcw_pkg::CNT_W'(1);
        end else if (!sc_pend) begin
          cursor_next = cursor - tcw_pkg::CURSOR_COLS;
          state_next  = S_PUT;
        end
      end
      S_MOD: begin
        if (rem >= tcw_pkg::CURSOR_COLS) begin
          rem_next = rem - tcw_pkg::CURSOR_COLS;
        end else begin
          cursor_next = cursor - rem;
          emit        = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        cnt_next = cnt + tcw_pkg::CNT_W'(1);
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
          cursor_next = '0;
          emit        = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_READ: begin
        emit_char  = mem_rdata[7:0];
        emit_attr  = mem_rdata[15:8];
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor       <= '0;
      attr         <= tcw_pkg::ATTR_RESET;
      sc_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      sc_pend      <= sc_pend_next;
      result_valid <= emit;
      if (cfg_write) begin
        attr <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    put_char <= put_char_next;
    cnt      <= cnt_next;
    sc_wa    <= sc_wa_next;
    if (emit) begin
      result.cursor_now <= cursor_next;
      result.cell_char  <= emit_char;
      result.cell_attr  <= emit_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Every accepted request either keeps the engine busy or reports at once.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || result_valid))
    else $error("accepted request neither busy nor reported");

  // The scroll copy never reads the cell it writes in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write collide");

  // A scroll runs only while the cursor is still past the screen end.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> (cursor >= tcw_pkg::CURSOR_END))
    else $error("scroll with cursor inside the screen");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: directed and random console
// commands, a scoreboard that predicts cursor and cell reads, and APB writes of
// the text attribute between phases. Depends on tcw_pkg and the RTL top level.
module tb_top;
  import tcw_pkg::*;

  class console_scoreboard;
    logic [15:0]         cells [CELL_COUNT];
    logic [CURSOR_W-1:0] cursor;
    logic [7:0]          attr;
    rsp_t                expected_q [$];
    int                  mismatches;

    function new();
      cursor     = '0;
      attr       = ATTR_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void note_request(req_t r);
      rsp_t       want;
      logic [7:0] ch;
      want = '0;
      case (r.command)
        CMD_PUT: begin
          while (cursor >= CURSOR_END) begin
            for (int k = 0; k < CELL_COUNT - COLUMNS; k++) cells[k] = cells[k + COLUMNS];
            cursor -= CURSOR_COLS;
          end
          if (r.char_byte == CH_NEWLINE) begin
            cursor += CURSOR_COLS;
          end else if (r.char_byte == CH_RETURN) begin
            cursor -= cursor % CURSOR_COLS;
          end else begin
            ch = (r.char_byte < CH_SPACE || r.char_byte >= CH_HIGH) ? CH_QUESTION : r.char_byte;
            if (cursor < CURSOR_END) cells[cursor] = {attr, ch};
            cursor++;
          end
        end
        CMD_SET: begin
          cursor = (r.position > CELL_COUNT) ? CURSOR_END : CURSOR_W'(r.position);
        end
        CMD_READ: begin
          if (r.position < CELL_COUNT) begin
            want.cell_char = cells[r.position][7:0];
            want.cell_attr = cells[r.position][15:8];
          end
        end
        default: begin
          for (int k = 0; k < CELL_COUNT; k++) cells[k] = {attr, CH_SPACE};
          cursor = '0;
        end
      endcase
      want.cursor_now = cursor;
      expected_q.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("result with no request pending: cursor %0d char %h attr %h",
                               got.cursor_now, got.cell_char, got.cell_attr));
        return;
      end
      want = expected_q.pop_front();
      if (got.cursor_now !== want.cursor_now || got.cell_char !== want.cell_char ||
          got.cell_attr !== want.cell_attr)
        note_failure($sformatf("expected cursor %0d char %h attr %h, got cursor %0d char %h attr %h",
                               want.cursor_now, want.cell_char, want.cell_attr,
                               got.cursor_now, got.cell_char, got.cell_attr));
    endfunction
  endclass

  localparam logic [2:0] ATTR_ADDR = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        result_valid;
  rsp_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb;
  bit                no_idle = 1'b0;
  int                scroll_budget = 150;

  text_console_writer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  function automatic req_t mk(cmd_t c, logic [7:0] ch, logic [POS_W-1:0] pos);
    req_t r;
    r.command   = c;
    r.char_byte = ch;
    r.position  = pos;
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 8'($urandom_range(32, 127));
    else if (sel < 67) return CH_NEWLINE;
    else if (sel < 75) return CH_RETURN;
    else if (sel < 87) return 8'($urandom_range(0, 31));
    else return 8'($urandom_range(128, 255));
  endfunction

  // Puts that would scroll are rationed, since each one copies all but the first row of the store.
  function automatic req_t pick_request();
    req_t r;
    int   sel;
    r.char_byte = 8'($urandom);
    r.position  = POS_W'($urandom);
    sel = $urandom_range(0, 255);
    if (sel < 2) begin
      r.command = CMD_CLEAR;
    end else if (sel < 60) begin
      r.command = CMD_SET;
      if ($urandom_range(0, 1) == 0) r.position = POS_W'($urandom_range(1900, 2047));
    end else if (sel < 110) begin
      r.command = CMD_READ;
      if ($urandom_range(0, 1) == 0)
        r.position = (sb.cursor >= 8) ? POS_W'(sb.cursor - $urandom_range(1, 8)) : '0;
    end else begin
      r.command   = CMD_PUT;
      r.char_byte = pick_char();
    end
    if (r.command == CMD_PUT && sb.cursor >= CURSOR_END) begin
      if (scroll_budget > 0 && $urandom_range(0, 3) == 0) begin
        scroll_budget--;
      end else begin
        r.command  = CMD_SET;
        r.position = POS_W'($urandom_range(0, CELL_COUNT - 1));
      end
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    int sel;
    gap = 0;
    if (!no_idle) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) gap = 0;
      else if (sel < 88) gap = $urandom_range(1, 3);
      else if (sel < 97) gap = $urandom_range(4, 20);
      else gap = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ATTR_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, 32'(value), rd);
    apb_xfer(1'b0, '0, rd);
    sb.attr = value;
    if (rd !== 32'(value))
      sb.note_failure($sformatf("attribute reads back %h, wrote %h", rd, value));
  endtask

  initial begin
    req_t       directed [$];
    logic [7:0] phase_attr;
    sb = new();
    // The store is only read at cell 0 before the first clear, after a put wrote it.
    directed = '{
      mk(CMD_PUT,   8'h41, 11'd0),    mk(CMD_READ,  8'h00, 11'd0),
      mk(CMD_CLEAR, 8'hff, 11'h7ff),  mk(CMD_READ,  8'h00, 11'd1999),
      mk(CMD_READ,  8'h00, 11'd2000), mk(CMD_READ,  8'hff, 11'd2047),
      mk(CMD_PUT,   8'h7f, 11'd0),    mk(CMD_PUT,   8'h00, 11'd0),
      mk(CMD_PUT,   8'h1f, 11'd0),    mk(CMD_PUT,   8'h80, 11'd0),
      mk(CMD_PUT,   8'hff, 11'h7ff),  mk(CMD_PUT,   CH_SPACE, 11'd0),
      mk(CMD_PUT,   CH_RETURN, 11'd0), mk(CMD_PUT,  CH_NEWLINE, 11'd0),
      mk(CMD_SET,   8'h00, 11'd2047), mk(CMD_PUT,   8'h42, 11'd0),
      mk(CMD_SET,   8'h00, 11'd2000), mk(CMD_PUT,   CH_NEWLINE, 11'd0),
      mk(CMD_PUT,   CH_RETURN, 11'd0), mk(CMD_SET,  8'h00, 11'd1999),
      mk(CMD_PUT,   CH_RETURN, 11'd0), mk(CMD_READ, 8'h00, 11'd1920),
      mk(CMD_READ,  8'h00, 11'd0),    mk(CMD_SET,   8'h00, 11'd0)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i]);
    finish_phase();
    for (int p = 0; p < 6; p++) begin
      phase_attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom);
      write_attr(phase_attr);
      for (int n = 0; n < 272; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_request(pick_request());
      end
      finish_phase();
    end
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(150_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
